// File: rtl/core/signed_int_to_decimal_ascii_macros.svh
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication, disabled in reset
`define SITDA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SITDA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sitda_pkg.sv
package sitda_pkg;

  localparam int DEF_VALUE_BITS = 32;
  localparam int CHAR_W = 6;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

  // decimal digits of 2^(bits-1), the largest magnitude
  function automatic int dec_digits(input int bits);
    return ((bits - 1) * 30103) / 100000 + 1;
  endfunction

endpackage

// File: rtl/core/signed_int_to_decimal_ascii.sv
// signed integer to decimal ascii text
// input channel s_*: one request carries a two's complement value in the
// low VALUE_BITS bits of s_tdata; s_tready is high only while the block
// is idle, so one value is converted at a time.
// output channel m_*: one character per request, most significant first,
// a leading minus sign for negative values, m_tlast on the final digit.
// zero gives a single '0'; leading zeros never appear.
// after the input request, the value passes one shift-add-3 step per
// bit through one shared bcd step unit, then the first character is
// valid. characters leave one per cycle while m_tready is high.
// a new value is taken only once the final character has left; a value
// gives up to 11 characters at 32 bits.
// a stalled receiver holds the current character and m_tlast stable;
// the block waits without losing state.
// reset (rst, synchronous) returns the block to idle and drops any text
// in progress.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = sitda_pkg::DEF_VALUE_BITS,
  localparam int IN_W = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [IN_W-1:0] s_tdata,   // value
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,   // char_code
  output logic            m_tlast    // last
);

  import sitda_pkg::*;

  localparam int NDIG   = dec_digits(VALUE_BITS);
  localparam int PTR_W  = $clog2(NDIG);
  localparam int NCNT_W = $clog2(NDIG + 1);
  localparam int CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                  state, state_next;
  logic [VALUE_BITS-1:0]   mag;
  logic [NDIG-1:0][3:0]    bcd;
  logic [NDIG-1:0][3:0]    bcd_step;
  logic [NCNT_W-1:0]       ndig, ndig_step;
  logic [CNT_W-1:0]        bit_cnt;
  logic [PTR_W-1:0]        ptr;
  logic                    sign_pend;
  logic [VALUE_BITS-1:0]   x_in;
  logic                    in_req, out_req;
  logic [CHAR_W-1:0]       char_code;

  assign in_req  = s_tvalid && s_tready;
  assign out_req = m_tvalid && m_tready;
  assign x_in    = s_tdata[VALUE_BITS-1:0];

  sitda_dabble #(.NDIG(NDIG)) u_dabble (
    .bcd_in  (bcd),
    .bit_in  (mag[VALUE_BITS-1]),
    .bcd_out (bcd_step)
  );

  // the number grows by at most one digit per step
  always_comb begin
    ndig_step = ndig;
    if (ndig < NCNT_W'(NDIG)) begin
      if (bcd_step[ndig[PTR_W-1:0]] != 4'd0) begin
        ndig_step = ndig + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_req) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (bit_cnt == '0) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_req && !sign_pend && ptr == '0) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_req) begin
          sign_pend <= x_in[VALUE_BITS-1];
          mag       <= x_in[VALUE_BITS-1] ? (~x_in + 1'b1) : x_in;
          bcd       <= '0;
          ndig      <= '0;
          bit_cnt   <= CNT_W'(VALUE_BITS - 1);
        end
      end
      ST_CONV: begin
        bcd     <= bcd_step;
        ndig    <= ndig_step;
        mag     <= {mag[VALUE_BITS-2:0], 1'b0};
        bit_cnt <= bit_cnt - 1'b1;
        ptr     <= (ndig_step == '0) ? '0 : PTR_W'(ndig_step - 1'b1);
      end
      ST_EMIT: begin
        if (out_req) begin
          if (sign_pend) begin
            sign_pend <= 1'b0;
          end else if (ptr != '0) begin
            ptr <= ptr - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign char_code = sign_pend ? CHAR_MINUS : CHAR_ZERO + {2'b00, bcd[ptr]};

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_EMIT);
  assign m_tdata  = {2'b00, char_code};
  assign m_tlast  = !sign_pend && (ptr == '0);

endmodule

// File: rtl/core/sitda_dabble.sv
module sitda_dabble #(
  parameter int NDIG = 10
) (
  input  logic [NDIG-1:0][3:0] bcd_in,
  input  logic                 bit_in,
  output logic [NDIG-1:0][3:0] bcd_out
);

  logic [NDIG-1:0][3:0] adj;

  // add 3 to every digit of 5 or more, then shift in the next bit
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i] = (bcd_in[i] >= 4'd5) ? bcd_in[i] + 4'd3 : bcd_in[i];
    end
  end

  assign bcd_out = (NDIG*4)'({adj, bit_in});

endmodule

// File: rtl/core/sitda_checker.sv
`include "signed_int_to_decimal_ascii_macros.svh"

module sitda_checker #(
  parameter int VALUE_BITS = sitda_pkg::DEF_VALUE_BITS,
  localparam int IN_W = ((VALUE_BITS + 7) / 8) * 8
) (
  input logic            clk,
  input logic            rst,
  input logic            s_tvalid,
  input logic            s_tready,
  input logic [IN_W-1:0] s_tdata,
  input logic            m_tvalid,
  input logic            m_tready,
  input logic [7:0]      m_tdata,
  input logic            m_tlast
);

  import sitda_pkg::*;

  logic char_ok;

  assign char_ok = (m_tdata[7:6] == 2'b00) &&
                   ((m_tdata[5:0] == CHAR_MINUS) ||
                    ((m_tdata[5:0] >= CHAR_ZERO) && (m_tdata[5:0] <= CHAR_NINE)));

  `SITDA_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled character changed")
  `SITDA_ASSERT_NEXT(a_in_hold, clk, rst, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata), "waiting request changed")
  `SITDA_ASSERT_NEXT(a_busy_after_in, clk, rst, s_tvalid && s_tready, !s_tready && !m_tvalid, "no conversion step after input")
  `SITDA_ASSERT_NOW(a_char_range, clk, rst, m_tvalid, char_ok, "character out of range")
  `SITDA_ASSERT_NOW(a_minus_not_last, clk, rst, m_tvalid && m_tdata[5:0] == CHAR_MINUS, !m_tlast, "minus sign marked last")

endmodule

bind signed_int_to_decimal_ascii sitda_checker #(.VALUE_BITS(VALUE_BITS)) u_sitda_checker (.*);
